/* hw/rtl/nrtt_pkg.sv */
// ----------------------------------------------------------------------------
// nrtt_pkg
// Shared types and constants for the node report top-two maximum block:
// table entry layout, table write request and selection unit op codes.
// ----------------------------------------------------------------------------
package nrtt_pkg;

	// default number of reporting nodes (legal range 2..7)
	localparam int NRTT_NODES = 6;

	// fixed field widths
	localparam int VOLT_W = 16;
	localparam int CELL_W = 8;
	localparam int NODE_W = 3;

	// one table entry: raw voltage, cell number and the node that wrote it
	typedef struct packed {
		logic [VOLT_W-1:0] volt;
		logic [CELL_W-1:0] cnum;
		logic [NODE_W-1:0] node;
	} entry_t;

	// table write request, both readings of one report
	typedef struct packed {
		logic              en;
		logic [NODE_W-1:0] node;
		entry_t            first;
		entry_t            second;
	} wr_req_t;

	// selection unit op codes
	localparam int PICK_OP_W = 2;
	localparam logic [PICK_OP_W-1:0] PICK_HOLD = 2'd0;
	localparam logic [PICK_OP_W-1:0] PICK_SEED = 2'd1;
	localparam logic [PICK_OP_W-1:0] PICK_PAIR = 2'd2;
	localparam logic [PICK_OP_W-1:0] PICK_SCAN = 2'd3;

endpackage

/* hw/rtl/node_report_top_two_max_core.sv */
// ----------------------------------------------------------------------------
// node_report_top_two_max_core
// Stores the two cell readings of each node report in an entry table and
// returns the highest and second-highest entries after every report.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | node, first_cell, first_volt,
//           |                      | second_cell, second_volt
//   out     | out_valid/ out_ready | top_volt, top_cell, top_node, runner_volt,
//           |                      | runner_cell, runner_node, bad_node
//
// each word is accepted in idle, then scanned one table row per cycle
// through the shared compare unit, then loaded as a result in the done state.
// in_ready is high only while idle; a new word may be taken while the last
// result still waits in the output register.
// a full output register holds the result cycle until out_ready.
// reset clears the table, the sequencer and out_valid; no clearing pass.
// ----------------------------------------------------------------------------
module node_report_top_two_max_core import nrtt_pkg::*; #(
	parameter int NODES = NRTT_NODES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [NODE_W-1:0] node,
	input  logic [CELL_W-1:0] first_cell,
	input  logic [VOLT_W-1:0] first_volt,
	input  logic [CELL_W-1:0] second_cell,
	input  logic [VOLT_W-1:0] second_volt,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [VOLT_W-1:0] top_volt,
	output logic [CELL_W-1:0] top_cell,
	output logic [NODE_W-1:0] top_node,
	output logic [VOLT_W-1:0] runner_volt,
	output logic [CELL_W-1:0] runner_cell,
	output logic [NODE_W-1:0] runner_node,
	output logic              bad_node
);

	localparam int ENTRIES = 2 * NODES;
	localparam int IDX_W   = $clog2(ENTRIES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]           state_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 bad_q;
	logic                 out_valid_q;
	logic                 in_fire;
	logic                 node_bad;
	logic                 out_free;
	logic [PICK_OP_W-1:0] pick_op;
	wr_req_t              wr;
	entry_t               rd_ent;
	entry_t               top;
	entry_t               runner;
	entry_t               top_q;
	entry_t               runner_q;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// node range check
	assign node_bad = (node == '0) || (node > NODE_W'(NODES));

	// table write for a good word
	always_comb begin
		wr             = '0;
		wr.en          = in_fire && !node_bad;
		wr.node        = node;
		wr.first.volt  = first_volt;
		wr.first.cnum  = first_cell;
		wr.first.node  = node;
		wr.second.volt = second_volt;
		wr.second.cnum = second_cell;
		wr.second.node = node;
	end

	nrtt_table #(
		.NODES   (NODES),
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_idx  (idx_q),
		.rd_data (rd_ent)
	);

	// op for the selection unit
	always_comb begin
		if (state_q != ST_SCAN) begin
			pick_op = PICK_HOLD;
		end else if (idx_q == '0) begin
			pick_op = PICK_SEED;
		end else if (idx_q == IDX_W'(1)) begin
			pick_op = PICK_PAIR;
		end else begin
			pick_op = PICK_SCAN;
		end
	end

	nrtt_pick u_pick (
		.clk    (clk),
		.op     (pick_op),
		.ent    (rd_ent),
		.top    (top),
		.runner (runner)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result word valid: set when loaded, cleared when taken
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (idx_q == IDX_W'(ENTRIES - 1)) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// flag of the word in flight
	always_ff @(posedge clk) begin
		if (in_fire) begin
			bad_q <= node_bad;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			top_q    <= top;
			runner_q <= runner;
			bad_node <= bad_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign top_volt    = top_q.volt;
	assign top_cell    = top_q.cnum;
	assign top_node    = top_q.node;
	assign runner_volt = runner_q.volt;
	assign runner_cell = runner_q.cnum;
	assign runner_node = runner_q.node;

endmodule

/* hw/rtl/nrtt_table.sv */
// ----------------------------------------------------------------------------
// nrtt_table
// Entry table of 2*NODES rows. Both readings of a report are written in the
// same cycle; one row is read per cycle at the scan index.
// ----------------------------------------------------------------------------
module nrtt_table import nrtt_pkg::*; #(
	parameter int NODES   = NRTT_NODES,
	parameter int ENTRIES = 2 * NODES,
	parameter int IDX_W   = $clog2(ENTRIES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  wr_req_t          wr,
	input  logic [IDX_W-1:0] rd_idx,
	output entry_t           rd_data
);

	entry_t           tbl_q [ENTRIES];
	logic [IDX_W-1:0] wr_a;
	logic [IDX_W-1:0] wr_b;

	// rows of the two readings of a node
	assign wr_a = IDX_W'(wr.node) - IDX_W'(1);
	assign wr_b = wr_a + IDX_W'(NODES);

	// table storage, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				tbl_q[i] <= '0;
			end
		end else if (wr.en) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (wr_a == IDX_W'(i)) begin
					tbl_q[i] <= wr.first;
				end else if (wr_b == IDX_W'(i)) begin
					tbl_q[i] <= wr.second;
				end
			end
		end
	end

	// scan read
	assign rd_data = tbl_q[rd_idx];

endmodule

/* hw/rtl/nrtt_pick.sv */
// ----------------------------------------------------------------------------
// nrtt_pick
// Shared selection unit: one entry per cycle goes through one pair of
// voltage compares that update the running top and runner.
// ----------------------------------------------------------------------------
module nrtt_pick import nrtt_pkg::*; (
	input  logic                 clk,
	input  logic [PICK_OP_W-1:0] op,
	input  entry_t               ent,
	output entry_t               top,
	output entry_t               runner
);

	entry_t top_q;
	entry_t runner_q;
	logic   above_top;
	logic   at_runner;

	// the shared compares
	assign above_top = top_q.volt < ent.volt;
	assign at_runner = runner_q.volt <= ent.volt;

	// running pair update
	always_ff @(posedge clk) begin
		unique case (op)
			PICK_SEED: begin
				top_q <= ent;
			end
			PICK_PAIR: begin
				// first row wins only when strictly larger
				if (top_q.volt > ent.volt) begin
					runner_q <= ent;
				end else begin
					top_q    <= ent;
					runner_q <= top_q;
				end
			end
			PICK_SCAN: begin
				if (above_top) begin
					top_q    <= ent;
					runner_q <= top_q;
				end else if (at_runner) begin
					runner_q <= ent;
				end
			end
			default: begin
			end
		endcase
	end

	assign top    = top_q;
	assign runner = runner_q;

endmodule

/* hw/rtl/nrtt_checker.sv */
// ----------------------------------------------------------------------------
// nrtt_checker
// Port-level checks for node_report_top_two_max_core, bound to the top.
// ----------------------------------------------------------------------------
module nrtt_checker import nrtt_pkg::*; #(
	parameter int NODES = NRTT_NODES
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [VOLT_W-1:0] top_volt,
	input logic [VOLT_W-1:0] runner_volt,
	input logic              bad_node
);

	localparam int ENTRIES = 2 * NODES;

	// busy right after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after an accepted word");

	// the scan of the whole table keeps the input closed
	a_busy_through_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> ##ENTRIES !in_ready)
		else $error("in_ready high before the table scan finished");

	// the top never ranks below the runner
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (top_volt >= runner_volt))
		else $error("top voltage below runner voltage");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(top_volt) && $stable(runner_volt) && $stable(bad_node)))
		else $error("result word changed while stalled");

endmodule

bind node_report_top_two_max_core nrtt_checker #(
	.NODES (NODES)
) u_nrtt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.top_volt    (top_volt),
	.runner_volt (runner_volt),
	.bad_node    (bad_node)
);

/* test/node_report_top_two_max_core_check.sv */
// ----------------------------------------------------------------------------
// node_report_top_two_max_core_check
// Watches both channels of the top-two maximum block. It keeps its own copy
// of the entry table, ranks the table for every accepted report word and
// compares each result word, field by field, with the oldest ranking due.
// ----------------------------------------------------------------------------
module node_report_top_two_max_core_check import nrtt_pkg::*; #(
	parameter int NODES = NRTT_NODES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [NODE_W-1:0] node,
	input  logic [CELL_W-1:0] first_cell,
	input  logic [VOLT_W-1:0] first_volt,
	input  logic [CELL_W-1:0] second_cell,
	input  logic [VOLT_W-1:0] second_volt,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [VOLT_W-1:0] top_volt,
	input  logic [CELL_W-1:0] top_cell,
	input  logic [NODE_W-1:0] top_node,
	input  logic [VOLT_W-1:0] runner_volt,
	input  logic [CELL_W-1:0] runner_cell,
	input  logic [NODE_W-1:0] runner_node,
	input  logic              bad_node,
	output int                fails,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// highest and second-highest entry plus the out-of-range flag
	typedef struct packed {
		entry_t top;
		entry_t runner;
		logic   bad;
	} top_two_t;

	entry_t   slots [2*NODES];
	top_two_t due_rankings [$];
	int       mismatches = 0;
	int       waiting = 0;

	assign fails   = mismatches;
	assign pending = waiting;

	// seed from entries 1 and 2, then sweep the rest in order
	function automatic top_two_t rank_slots(input logic bad);
		top_two_t r;
		int       j;
		r.bad = bad;
		if (slots[0].volt > slots[1].volt) begin
			r.top    = slots[0];
			r.runner = slots[1];
		end else begin
			r.top    = slots[1];
			r.runner = slots[0];
		end
		for (j = 2; j < 2*NODES; j++) begin
			if (slots[j].volt > r.top.volt) begin
				r.runner = r.top;
				r.top    = slots[j];
			end else if (slots[j].volt >= r.runner.volt) begin
				r.runner = slots[j];
			end
		end
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [VOLT_W-1:0] want,
			input logic [VOLT_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// result words are retired before the report word of the same edge is ranked
	always @(posedge clk or negedge arst_n) begin : watch
		top_two_t due;
		logic     off_range;
		int       k;
		int       slot;
		if (!arst_n) begin
			for (k = 0; k < 2*NODES; k++)
				slots[k] = '0;
			due_rankings.delete();
			waiting = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_rankings.size() == 0) begin
					$error("result word with no report pending");
					mismatches++;
				end else begin
					due = due_rankings.pop_front();
					compare_field("top_volt", due.top.volt, top_volt);
					compare_field("top_cell", VOLT_W'(due.top.cnum), VOLT_W'(top_cell));
					compare_field("top_node", VOLT_W'(due.top.node), VOLT_W'(top_node));
					compare_field("runner_volt", due.runner.volt, runner_volt);
					compare_field("runner_cell", VOLT_W'(due.runner.cnum),
						VOLT_W'(runner_cell));
					compare_field("runner_node", VOLT_W'(due.runner.node),
						VOLT_W'(runner_node));
					compare_field("bad_node", VOLT_W'(due.bad), VOLT_W'(bad_node));
				end
			end
			if (in_valid && in_ready) begin
				off_range = (node < 1) || (int'(node) > NODES);
				// a valid node writes both of its readings
				if (!off_range) begin
					slot = int'(node) - 1;
					slots[slot].volt       = first_volt;
					slots[slot].cnum       = first_cell;
					slots[slot].node       = node;
					slots[slot+NODES].volt = second_volt;
					slots[slot+NODES].cnum = second_cell;
					slots[slot+NODES].node = node;
				end
				due_rankings.push_back(rank_slots(off_range));
			end
			waiting = due_rankings.size();
		end
	end

endmodule

/* test/node_report_top_two_max_core_test.sv */
// ----------------------------------------------------------------------------
// node_report_top_two_max_core_test
// Drives node report words into the top-two maximum block with random gaps
// and result stalls: a directed set of extremes, ties and bad nodes first,
// then random reports. The checker beside the block ranks and compares.
// ----------------------------------------------------------------------------
module node_report_top_two_max_core_test;
	import nrtt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_COUNT = 1400;
	localparam int CYCLE_LIMIT  = 400000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [NODE_W-1:0] node = '0;
	logic [CELL_W-1:0] first_cell = '0;
	logic [VOLT_W-1:0] first_volt = '0;
	logic [CELL_W-1:0] second_cell = '0;
	logic [VOLT_W-1:0] second_volt = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [VOLT_W-1:0] top_volt;
	logic [CELL_W-1:0] top_cell;
	logic [NODE_W-1:0] top_node;
	logic [VOLT_W-1:0] runner_volt;
	logic [CELL_W-1:0] runner_cell;
	logic [NODE_W-1:0] runner_node;
	logic              bad_node;
	int                fails;
	int                pending;
	int                cycle_count = 0;
	bit                steady_in = 1'b0;
	bit                steady_out = 1'b0;

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	node_report_top_two_max_core #(.NODES(NRTT_NODES)) dut (.*);

	node_report_top_two_max_core_check #(.NODES(NRTT_NODES)) check (.*);

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("node_report_top_two_max_core_test: done, errors");
			$finish;
		end
	end

	// result side: random stall per word, with calm stretches
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				steady_out = !steady_out;
			stall = steady_out ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// one report word, after a random gap; called at a rising edge
	task automatic offer_report(input logic [NODE_W-1:0] n, input logic [CELL_W-1:0] fc,
			input logic [VOLT_W-1:0] fv, input logic [CELL_W-1:0] sc,
			input logic [VOLT_W-1:0] sv);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0)
			steady_in = !steady_in;
		gap = steady_in ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		node        <= n;
		first_cell  <= fc;
		first_volt  <= fv;
		second_cell <= sc;
		second_volt <= sv;
		do @(posedge clk); while (!in_ready);
	endtask

	// voltage mix: full range, tie-prone cluster, extremes, typical band
	function automatic logic [VOLT_W-1:0] draw_volt();
		case ($urandom_range(0, 3))
			0: return VOLT_W'($urandom_range(0, 65535));
			1: return VOLT_W'(4000 + $urandom_range(0, 3));
			2: return $urandom_range(0, 1) ? 16'hFFFF : VOLT_W'($urandom_range(0, 1));
			default: return VOLT_W'($urandom_range(2500, 4200));
		endcase
	endfunction

	function automatic logic [NODE_W-1:0] draw_node();
		if ($urandom_range(0, 9) != 0)
			return NODE_W'($urandom_range(1, NRTT_NODES));
		if (NRTT_NODES == 7 || $urandom_range(0, 1) == 0)
			return '0;
		return NODE_W'($urandom_range(NRTT_NODES + 1, 7));
	endfunction

	initial begin
		int i;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bad nodes on the cleared table
		offer_report(3'd0, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
		offer_report(3'd7, 8'h00, 16'h0000, 8'h00, 16'h0000);
		// zero readings, then ties at full scale
		offer_report(3'd1, 8'h00, 16'h0000, 8'h00, 16'h0000);
		offer_report(3'd2, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
		offer_report(3'd3, 8'h01, 16'hFFFF, 8'h02, 16'hFFFF);
		offer_report(3'd6, 8'h55, 16'hAAAA, 8'hAA, 16'h5555);
		offer_report(3'd4, 8'h10, 16'h1234, 8'h11, 16'h8000);
		offer_report(3'd5, 8'h20, 16'h7FFF, 8'h21, 16'h0001);
		// tie between the two seeding entries, then one strictly larger
		offer_report(3'd1, 8'h30, 16'hFFFF, 8'h31, 16'h0000);
		offer_report(3'd2, 8'h40, 16'h0000, 8'h41, 16'h0000);
		// whole table at one voltage
		for (i = 1; i <= NRTT_NODES; i++)
			offer_report(NODE_W'(i), CELL_W'(i), 16'd1000, CELL_W'(i + 8), 16'd1000);
		// strict rise past the top, then bad nodes on a full table
		offer_report(3'd4, 8'hFE, 16'd1001, 8'h01, 16'd999);
		offer_report(3'd0, 8'h00, 16'h0000, 8'h00, 16'h0000);
		offer_report(3'd7, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);

		// random reports
		for (i = 0; i < REPORT_COUNT; i++)
			offer_report(draw_node(), CELL_W'($urandom_range(0, 255)), draw_volt(),
				CELL_W'($urandom_range(0, 255)), draw_volt());
		in_valid <= 1'b0;

		// drain, then give a late stray word time to show
		while (pending != 0) @(posedge clk);
		repeat (4 * NRTT_NODES + 8) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("node_report_top_two_max_core_test: done, clean");
		else
			$display("node_report_top_two_max_core_test: done, errors");
		$finish;
	end

endmodule
